// File: rtl/core/ptcg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcg_pkg
// Shared types, constants and the sine table of the planar texture
// coordinate generator.
// ----------------------------------------------------------------------------
package ptcg_pkg;

   localparam int POINT_W  = 32;
   localparam int FIELD_W  = 16;
   localparam int SIZE_W   = 13;
   localparam int COORD_W  = 32;
   localparam int REQ_W    = 224;
   localparam int RSP_W    = 64;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_TEX_WIDTH  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEX_HEIGHT = 1'd1;
   localparam logic [SIZE_W-1:0]    TEX_SIZE_RESET = 13'd64;

   // dividend bits of the two restoring dividers in each lane
   localparam int DIV1_BITS = 55;
   localparam int DIV1_REM  = 16;
   localparam int DIV2_BITS = 43;
   localparam int DIV2_REM  = 13;

   localparam logic [63:0] Q30_ONE         = 64'd1073741824;
   localparam logic [63:0] COS_ONE_DEG_Q30 = 64'd1073578288;
   localparam logic [63:0] SIN_ONE_DEG_Q30 = 64'd18739379;

   typedef enum logic [2:0] {
      AXIS_FLOOR,
      AXIS_CEILING,
      AXIS_WEST,
      AXIS_EAST,
      AXIS_SOUTH,
      AXIS_NORTH
   } axis_type;

   typedef enum logic [1:0] {
      QUAD_0,
      QUAD_90,
      QUAD_180,
      QUAD_270
   } quad_type;

   typedef struct packed {
      logic signed [POINT_W-1:0] ps;
      logic signed [POINT_W-1:0] pt;
      logic signed [FIELD_W-1:0] scale_s;
      logic signed [FIELD_W-1:0] scale_t;
      logic signed [FIELD_W-1:0] offset_s;
      logic signed [FIELD_W-1:0] offset_t;
   } geo_type;

   typedef logic signed [FIELD_W-1:0] sin_tab_type [0:90];

   // Quarter-wave sine in Q2.14, built by stepping a Q30 rotation one degree
   // at a time; evaluated at elaboration only.
   function automatic sin_tab_type build_sin_tab();
      sin_tab_type tab;
      logic [63:0] c;
      logic [63:0] s;
      logic [63:0] nc;
      logic [63:0] v;
      int k;
      for (int d = 0; d <= 90; d++) begin
         k = (d <= 45) ? d : 90 - d;
         c = Q30_ONE;
         s = 64'd0;
         for (int i = 0; i < k; i++) begin
            nc = (c * COS_ONE_DEG_Q30 - s * SIN_ONE_DEG_Q30 + 64'd536870912) >> 30;
            s  = (s * COS_ONE_DEG_Q30 + c * SIN_ONE_DEG_Q30 + 64'd536870912) >> 30;
            c  = nc;
         end
         v = (d <= 45) ? s : c;
         tab[d] = FIELD_W'((v + 64'd32768) >> 16);
      end
      return tab;
   endfunction

   localparam sin_tab_type SIN_TAB = build_sin_tab();

endpackage

// File: rtl/core/ptcg_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptcg_lane
// One texture axis: dot product, divide by scale, add offset, divide by the
// texture size and saturate. Fully pipelined, one item per cycle while en is high.
// ----------------------------------------------------------------------------
module ptcg_lane (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  en,
   input  logic                                  in_valid,
   input  logic signed [ptcg_pkg::POINT_W-1:0]   ps,
   input  logic signed [ptcg_pkg::POINT_W-1:0]   pt,
   input  logic signed [ptcg_pkg::FIELD_W-1:0]   k0,
   input  logic signed [ptcg_pkg::FIELD_W-1:0]   k1,
   input  logic signed [ptcg_pkg::FIELD_W-1:0]   scale,
   input  logic signed [ptcg_pkg::FIELD_W-1:0]   offset,
   input  logic        [ptcg_pkg::SIZE_W-1:0]    size,
   output logic                                  out_valid,
   output logic signed [ptcg_pkg::COORD_W-1:0]   coord
);
   import ptcg_pkg::*;

   // products
   logic                      l1_valid_ff;
   logic signed [47:0]        l1_prod0_ff;
   logic signed [47:0]        l1_prod1_ff;
   logic signed [FIELD_W-1:0] l1_scale_ff;
   logic signed [FIELD_W-1:0] l1_off_ff;

   // dot product
   logic                      l2_valid_ff;
   logic signed [48:0]        l2_dot_ff;
   logic signed [FIELD_W-1:0] l2_scale_ff;
   logic signed [FIELD_W-1:0] l2_off_ff;

   // divider by scale
   logic                      d1_valid_ff [0:DIV1_BITS];
   logic [DIV1_BITS-1:0]      d1_dq_ff    [0:DIV1_BITS];
   logic [DIV1_REM-1:0]       d1_rem_ff   [0:DIV1_BITS];
   logic [DIV1_REM-1:0]       d1_den_ff   [0:DIV1_BITS];
   logic                      d1_neg_ff   [0:DIV1_BITS];
   logic signed [FIELD_W-1:0] d1_off_ff   [0:DIV1_BITS];

   logic                      l3_neg_in;
   logic [46:0]               l3_mag_in;
   logic [DIV1_REM-1:0]       l3_den_in;

   // offset sum
   logic                      l4_valid_ff;
   logic signed [56:0]        l4_sum_ff;
   logic signed [56:0]        l4_q_in;

   // divider by texture size
   logic                      d2_valid_ff [0:DIV2_BITS];
   logic [DIV2_BITS-1:0]      d2_dq_ff    [0:DIV2_BITS];
   logic [DIV2_REM-1:0]       d2_rem_ff   [0:DIV2_BITS];
   logic [DIV2_REM-1:0]       d2_den_ff   [0:DIV2_BITS];
   logic                      d2_neg_ff   [0:DIV2_BITS];

   logic [55:0]               l5_mag_in;
   logic [56:0]               l5_biased_in;

   logic                      fin_valid_ff;
   logic signed [COORD_W-1:0] fin_coord_ff;
   logic signed [COORD_W-1:0] fin_coord_in;
   logic [DIV2_BITS-1:0]      fin_q;

   // ---- stage 1: multiply
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
      end else if (en) begin
         l1_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l1_prod0_ff <= 48'(ps) * 48'(k0);
         l1_prod1_ff <= 48'(pt) * 48'(k1);
         l1_scale_ff <= scale;
         l1_off_ff   <= offset;
      end
   end

   // ---- stage 2: add
   always_ff @(posedge clock) begin
      if (reset) begin
         l2_valid_ff <= 1'b0;
      end else if (en) begin
         l2_valid_ff <= l1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l2_dot_ff   <= 49'(l1_prod0_ff) + 49'(l1_prod1_ff);
         l2_scale_ff <= l1_scale_ff;
         l2_off_ff   <= l1_off_ff;
      end
   end

   // ---- stage 3: sign and magnitude, rounding bias for the scale divide
   always_comb begin
      l3_neg_in = l2_dot_ff[48] ^ l2_scale_ff[FIELD_W-1];
      l3_mag_in = l2_dot_ff[48] ? 47'(-l2_dot_ff) : 47'(l2_dot_ff);
      if (l2_scale_ff == '0) begin
         l3_den_in = DIV1_REM'(256);
      end else if (l2_scale_ff[FIELD_W-1]) begin
         l3_den_in = DIV1_REM'(-l2_scale_ff);
      end else begin
         l3_den_in = DIV1_REM'(l2_scale_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d1_valid_ff[0] <= 1'b0;
      end else if (en) begin
         d1_valid_ff[0] <= l2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d1_dq_ff[0]  <= {l3_mag_in, 8'd0} + DIV1_BITS'(l3_den_in >> 1);
         d1_rem_ff[0] <= '0;
         d1_den_ff[0] <= l3_den_in;
         d1_neg_ff[0] <= l3_neg_in;
         d1_off_ff[0] <= l2_off_ff;
      end
   end

   // one quotient bit per stage
   for (genvar g = 0; g < DIV1_BITS; g++) begin : g_div1
      logic [DIV1_REM:0]   trial;
      logic                ge;
      logic [DIV1_REM-1:0] rem_in;

      always_comb begin
         trial  = {d1_rem_ff[g], d1_dq_ff[g][DIV1_BITS-1]};
         ge     = trial >= {1'b0, d1_den_ff[g]};
         rem_in = ge ? DIV1_REM'(trial - {1'b0, d1_den_ff[g]}) : trial[DIV1_REM-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d1_valid_ff[g+1] <= 1'b0;
         end else if (en) begin
            d1_valid_ff[g+1] <= d1_valid_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d1_dq_ff[g+1]  <= {d1_dq_ff[g][DIV1_BITS-2:0], ge};
            d1_rem_ff[g+1] <= rem_in;
            d1_den_ff[g+1] <= d1_den_ff[g];
            d1_neg_ff[g+1] <= d1_neg_ff[g];
            d1_off_ff[g+1] <= d1_off_ff[g];
         end
      end
   end

   // ---- stage 4: apply sign, add offset in Q.30
   always_comb begin
      l4_q_in = $signed({2'b00, d1_dq_ff[DIV1_BITS]});
      if (d1_neg_ff[DIV1_BITS]) begin
         l4_q_in = -l4_q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         l4_valid_ff <= 1'b0;
      end else if (en) begin
         l4_valid_ff <= d1_valid_ff[DIV1_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         l4_sum_ff <= l4_q_in + (57'(d1_off_ff[DIV1_BITS]) <<< 30);
      end
   end

   // ---- stage 5: magnitude, rounding bias, drop the 2^14 factor
   always_comb begin
      l5_mag_in    = l4_sum_ff[56] ? 56'(-l4_sum_ff) : 56'(l4_sum_ff);
      l5_biased_in = 57'(l5_mag_in) + (57'(size) << 13);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         d2_valid_ff[0] <= 1'b0;
      end else if (en) begin
         d2_valid_ff[0] <= l4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_dq_ff[0]  <= l5_biased_in[56:14];
         d2_rem_ff[0] <= '0;
         d2_den_ff[0] <= size;
         d2_neg_ff[0] <= l4_sum_ff[56];
      end
   end

   for (genvar g = 0; g < DIV2_BITS; g++) begin : g_div2
      logic [DIV2_REM:0]   trial;
      logic                ge;
      logic [DIV2_REM-1:0] rem_in;

      always_comb begin
         trial  = {d2_rem_ff[g], d2_dq_ff[g][DIV2_BITS-1]};
         ge     = trial >= {1'b0, d2_den_ff[g]};
         rem_in = ge ? DIV2_REM'(trial - {1'b0, d2_den_ff[g]}) : trial[DIV2_REM-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            d2_valid_ff[g+1] <= 1'b0;
         end else if (en) begin
            d2_valid_ff[g+1] <= d2_valid_ff[g];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            d2_dq_ff[g+1]  <= {d2_dq_ff[g][DIV2_BITS-2:0], ge};
            d2_rem_ff[g+1] <= rem_in;
            d2_den_ff[g+1] <= d2_den_ff[g];
            d2_neg_ff[g+1] <= d2_neg_ff[g];
         end
      end
   end

   // ---- final: sign and saturate
   always_comb begin
      fin_q = d2_dq_ff[DIV2_BITS];
      if (d2_neg_ff[DIV2_BITS]) begin
         if (fin_q > DIV2_BITS'(64'h8000_0000)) begin
            fin_coord_in = {1'b1, {(COORD_W-1){1'b0}}};
         end else begin
            fin_coord_in = COORD_W'(-fin_q);
         end
      end else begin
         if (fin_q > DIV2_BITS'(64'h7FFF_FFFF)) begin
            fin_coord_in = {1'b0, {(COORD_W-1){1'b1}}};
         end else begin
            fin_coord_in = COORD_W'(fin_q);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else if (en) begin
         fin_valid_ff <= d2_valid_ff[DIV2_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_coord_ff <= fin_coord_in;
      end
   end

   assign out_valid = fin_valid_ff;
   assign coord     = fin_coord_ff;

endmodule

// File: rtl/core/planar_texture_coord_gen_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_texture_coord_gen_core
// Planar texture projection of one vertex to (u, v) in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one vertex with its face normal, rotation, offsets and
//   scales per item; rsp_* returns coord_u and coord_v for that item, in
//   order. csr_* writes tex_width (index 0) and tex_height (index 1); write
//   them only while no item is in flight. A size of zero acts as one.
//   Throughput is one item per clock while the output is not stalled. From the
//   accepting edge to rsp_tvalid an item passes four stages for axis choice and
//   sine/cosine lookup, three for the dot product, a 55-stage divider by the
//   scale, two stages for the offset, a 43-stage divider by the texture size,
//   one saturation stage and the output register.
//   When the receiver stalls, one more item lands in a skid register and
//   req_tready then drops; the whole pipeline holds until the skid drains.
//   Reset empties the pipeline and sets both texture sizes to 64.
// ----------------------------------------------------------------------------
module planar_texture_coord_gen_core (
   input  logic                             clock,
   input  logic                             reset,
   // point_x, point_y, point_z, normal_x, normal_y, normal_z, rotation_deg,
   // offset_s, offset_t, scale_s, scale_t
   input  logic [ptcg_pkg::REQ_W-1:0]       req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // coord_u, coord_v
   output logic [ptcg_pkg::RSP_W-1:0]       rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_wen,
   input  logic [ptcg_pkg::CSR_IDX_W-1:0]   csr_addr,
   input  logic [ptcg_pkg::SIZE_W-1:0]      csr_wdata
);
   import ptcg_pkg::*;

   logic [SIZE_W-1:0] tex_width_ff;
   logic [SIZE_W-1:0] tex_height_ff;
   logic [SIZE_W-1:0] width_eff;
   logic [SIZE_W-1:0] height_eff;

   logic en;

   // input fields
   logic signed [POINT_W-1:0] in_px, in_py, in_pz;
   logic signed [FIELD_W-1:0] in_nx, in_ny, in_nz, in_rot;
   logic signed [FIELD_W-1:0] in_off_s, in_off_t, in_scale_s, in_scale_t;

   // stage 1
   logic                      t1_valid_ff;
   logic signed [POINT_W-1:0] t1_px_ff, t1_py_ff, t1_pz_ff;
   logic signed [FIELD_W-1:0] t1_scale_s_ff, t1_scale_t_ff, t1_off_s_ff, t1_off_t_ff;
   axis_type                  t1_axis_ff;
   axis_type                  t1_axis_in;
   logic [15:0]               t1_rotu_ff;
   logic [15:0]               t1_rotu_in;
   logic [7:0]                t1_quot_ff;
   logic signed [16:0]        dots [0:5];
   logic signed [16:0]        best;

   // stage 2
   logic                      t2_valid_ff;
   geo_type                   t2_geo_ff;
   geo_type                   t2_geo_in;
   logic [8:0]                t2_mod_ff;
   logic [8:0]                t2_mod_in;
   logic [16:0]               t2_raw;
   logic [9:0]                t2_rem;

   // stage 3
   logic                      t3_valid_ff;
   geo_type                   t3_geo_ff;
   quad_type                  t3_quad_ff;
   quad_type                  t3_quad_in;
   logic [6:0]                t3_deg_ff;
   logic [6:0]                t3_deg_in;

   // stage 4
   logic                      t4_valid_ff;
   geo_type                   t4_geo_ff;
   logic signed [FIELD_W-1:0] t4_sin_ff, t4_cos_ff, t4_ncos_ff;
   logic signed [FIELD_W-1:0] t4_sin_in, t4_cos_in;
   logic signed [FIELD_W-1:0] sd, cd;

   // lanes
   logic                      u_valid, v_valid;
   logic signed [COORD_W-1:0] u_coord, v_coord;

   // output register and skid
   logic                      rsp_valid_ff;
   logic [RSP_W-1:0]          rsp_data_ff;
   logic                      skid_valid_ff;
   logic [RSP_W-1:0]          skid_data_ff;
   logic                      out_free;

   // ---- configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         tex_width_ff  <= TEX_SIZE_RESET;
         tex_height_ff <= TEX_SIZE_RESET;
      end else if (csr_wen) begin
         case (csr_addr)
            CSR_TEX_WIDTH:  tex_width_ff  <= csr_wdata;
            CSR_TEX_HEIGHT: tex_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign width_eff  = (tex_width_ff == '0)  ? SIZE_W'(1) : tex_width_ff;
   assign height_eff = (tex_height_ff == '0) ? SIZE_W'(1) : tex_height_ff;

   // the whole pipeline advances while the skid register is empty
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   assign in_px      = req_tdata[31:0];
   assign in_py      = req_tdata[63:32];
   assign in_pz      = req_tdata[95:64];
   assign in_nx      = req_tdata[111:96];
   assign in_ny      = req_tdata[127:112];
   assign in_nz      = req_tdata[143:128];
   assign in_rot     = req_tdata[159:144];
   assign in_off_s   = req_tdata[175:160];
   assign in_off_t   = req_tdata[191:176];
   assign in_scale_s = req_tdata[207:192];
   assign in_scale_t = req_tdata[223:208];

   // ---- stage 1: base axis, first step of the angle reduction
   always_comb begin
      dots[0] = 17'(in_nz);
      dots[1] = -17'(in_nz);
      dots[2] = 17'(in_nx);
      dots[3] = -17'(in_nx);
      dots[4] = 17'(in_ny);
      dots[5] = -17'(in_ny);
      best       = '0;
      t1_axis_in = AXIS_FLOOR;
      // strict compare keeps the earlier axis on a tie
      for (int i = 0; i < 6; i++) begin
         if (dots[i] > best) begin
            best       = dots[i];
            t1_axis_in = axis_type'(3'(i));
         end
      end
      // bias the angle to unsigned; 32768 mod 360 is 8
      t1_rotu_in = {~in_rot[15], in_rot[14:0]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
      end else if (en) begin
         t1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_px_ff      <= in_px;
         t1_py_ff      <= in_py;
         t1_pz_ff      <= in_pz;
         t1_scale_s_ff <= in_scale_s;
         t1_scale_t_ff <= in_scale_t;
         t1_off_s_ff   <= in_off_s;
         t1_off_t_ff   <= in_off_t;
         t1_axis_ff    <= t1_axis_in;
         t1_rotu_ff    <= t1_rotu_in;
         // estimate of rotu / 360, low by at most one
         t1_quot_ff    <= 8'((24'(t1_rotu_in) * 24'd182) >> 16);
      end
   end

   // ---- stage 2: angle modulo 360, pick the projected point components
   always_comb begin
      t2_raw = 17'(t1_rotu_ff) - 17'(t1_quot_ff) * 17'd360;
      t2_rem = (t2_raw >= 17'd360) ? 10'(t2_raw - 17'd360) : 10'(t2_raw);
      t2_mod_in = (t2_rem >= 10'd8) ? 9'(t2_rem - 10'd8) : 9'(t2_rem + 10'd352);

      t2_geo_in.scale_s  = t1_scale_s_ff;
      t2_geo_in.scale_t  = t1_scale_t_ff;
      t2_geo_in.offset_s = t1_off_s_ff;
      t2_geo_in.offset_t = t1_off_t_ff;
      case (t1_axis_ff)
         AXIS_FLOOR, AXIS_CEILING: begin
            t2_geo_in.ps = t1_px_ff;
            t2_geo_in.pt = t1_py_ff;
         end
         AXIS_WEST, AXIS_EAST: begin
            t2_geo_in.ps = t1_py_ff;
            t2_geo_in.pt = t1_pz_ff;
         end
         default: begin
            t2_geo_in.ps = t1_px_ff;
            t2_geo_in.pt = t1_pz_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t2_valid_ff <= 1'b0;
      end else if (en) begin
         t2_valid_ff <= t1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t2_geo_ff <= t2_geo_in;
         t2_mod_ff <= t2_mod_in;
      end
   end

   // ---- stage 3: quadrant and angle within it
   always_comb begin
      if (t2_mod_ff < 9'd90) begin
         t3_quad_in = QUAD_0;
         t3_deg_in  = 7'(t2_mod_ff);
      end else if (t2_mod_ff < 9'd180) begin
         t3_quad_in = QUAD_90;
         t3_deg_in  = 7'(t2_mod_ff - 9'd90);
      end else if (t2_mod_ff < 9'd270) begin
         t3_quad_in = QUAD_180;
         t3_deg_in  = 7'(t2_mod_ff - 9'd180);
      end else begin
         t3_quad_in = QUAD_270;
         t3_deg_in  = 7'(t2_mod_ff - 9'd270);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t3_valid_ff <= 1'b0;
      end else if (en) begin
         t3_valid_ff <= t2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t3_geo_ff  <= t2_geo_ff;
         t3_quad_ff <= t3_quad_in;
         t3_deg_ff  <= t3_deg_in;
      end
   end

   // ---- stage 4: sine and cosine lookup
   always_comb begin
      sd = SIN_TAB[t3_deg_ff];
      cd = SIN_TAB[7'd90 - t3_deg_ff];
      case (t3_quad_ff)
         QUAD_0: begin
            t4_sin_in = sd;
            t4_cos_in = cd;
         end
         QUAD_90: begin
            t4_sin_in = cd;
            t4_cos_in = -sd;
         end
         QUAD_180: begin
            t4_sin_in = -sd;
            t4_cos_in = -cd;
         end
         default: begin
            t4_sin_in = -cd;
            t4_cos_in = sd;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t4_valid_ff <= 1'b0;
      end else if (en) begin
         t4_valid_ff <= t3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t4_geo_ff  <= t3_geo_ff;
         t4_sin_ff  <= t4_sin_in;
         t4_cos_ff  <= t4_cos_in;
         t4_ncos_ff <= -t4_cos_in;
      end
   end

   // ---- projection lanes: u = ps*cos + pt*sin, v = ps*sin - pt*cos
   ptcg_lane u_lane (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t4_valid_ff),
      .ps        (t4_geo_ff.ps),
      .pt        (t4_geo_ff.pt),
      .k0        (t4_cos_ff),
      .k1        (t4_sin_ff),
      .scale     (t4_geo_ff.scale_s),
      .offset    (t4_geo_ff.offset_s),
      .size      (width_eff),
      .out_valid (u_valid),
      .coord     (u_coord)
   );

   ptcg_lane v_lane (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (t4_valid_ff),
      .ps        (t4_geo_ff.ps),
      .pt        (t4_geo_ff.pt),
      .k0        (t4_sin_ff),
      .k1        (t4_ncos_ff),
      .scale     (t4_geo_ff.scale_t),
      .offset    (t4_geo_ff.offset_t),
      .size      (height_eff),
      .out_valid (v_valid),
      .coord     (v_coord)
   );

   // ---- output register with skid
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff  <= u_valid;
         end
      end else if (u_valid && en) begin
         // output stalled: park the arriving item
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         rsp_data_ff <= skid_valid_ff ? skid_data_ff : {v_coord, u_coord};
      end
      if (!out_free && en) begin
         skid_data_ff <= {v_coord, u_coord};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_lanes_aligned: assert property (@(posedge clock) disable iff (reset)
      u_valid == v_valid)
      else $error("u and v lanes out of step");

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds an item while output register is empty");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_valid_ff && !rsp_tready) |=> skid_valid_ff)
      else $error("skid item dropped during stall");
`endif

endmodule

// File: verif/tb_planar_texture_coord_gen_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_planar_texture_coord_gen_core
// Self-checking testbench: drives vertices with random gaps and back-pressure,
// predicts coord_u / coord_v in fixed point and compares every result in order.
// ----------------------------------------------------------------------------
module tb_planar_texture_coord_gen_core;
   import ptcg_pkg::*;

   typedef struct {
      logic signed [31:0] px, py, pz;
      logic signed [15:0] nx, ny, nz;
      logic signed [15:0] rot, off_s, off_t, scl_s, scl_t;
   } vertex_type;

   typedef struct {
      logic [31:0] u;
      logic [31:0] v;
   } coord_type;

   localparam int WATCHDOG_LIMIT = 4000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic [REQ_W-1:0]  req_tdata = '0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_addr = '0;
   logic [SIZE_W-1:0] csr_wdata = '0;

   coord_type   coord_q[$];
   int          errors = 0;
   int          stall_cycles = 0;
   bit          steady = 1'b0;    // no idling on either side while set
   logic [SIZE_W-1:0] width_reg, height_reg;
   longint      sine_q14[0:90];

   planar_texture_coord_gen_core dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // quarter-wave sine: step a Q30 rotation one degree at a time
   initial begin
      longint unsigned c, s, nc, w;
      int k;
      for (int d = 0; d <= 90; d++) begin
         k = (d <= 45) ? d : 90 - d;
         c = 64'd1073741824;
         s = 0;
         for (int i = 0; i < k; i++) begin
            nc = (c * 64'd1073578288 - s * 64'd18739379 + 64'd536870912) >> 30;
            s  = (s * 64'd1073578288 + c * 64'd18739379 + 64'd536870912) >> 30;
            c  = nc;
         end
         w = (d <= 45) ? s : c;
         sine_q14[d] = longint'((w + 64'd32768) >> 16);
      end
   end

   function automatic longint round_div(longint num, longint den);
      longint unsigned mag, q;
      mag = (num < 0) ? longint'(-num) : num;
      q = (mag + den / 2) / den;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [31:0] project_axis(longint dot, logic signed [15:0] scl,
                                                logic signed [15:0] off,
                                                logic [SIZE_W-1:0] size);
      longint num, den, sum;
      num = dot * 256;
      den = (scl == 0) ? 256 : longint'(scl);
      if (den < 0) begin
         num = -num;
         den = -den;
      end
      sum = round_div(num, den) + longint'(off) * 64'sd1073741824;
      sum = round_div(sum, ((size == 0) ? 64'sd1 : longint'(size)) * 16384);
      if (sum > 64'sd2147483647) sum = 64'sd2147483647;
      if (sum < -64'sd2147483648) sum = -64'sd2147483648;
      return sum[31:0];
   endfunction

   function automatic coord_type texture_coords(vertex_type vx);
      longint  dots[6], best, sn, cs, ps, pt;
      axis_type ax;
      int      m, d;
      coord_type r;
      dots[0] = vx.nz; dots[1] = -longint'(vx.nz);
      dots[2] = vx.nx; dots[3] = -longint'(vx.nx);
      dots[4] = vx.ny; dots[5] = -longint'(vx.ny);
      best = 0;
      ax = AXIS_FLOOR;
      for (int i = 0; i < 6; i++) begin
         if (dots[i] > best) begin
            best = dots[i];
            ax = axis_type'(i);
         end
      end
      m = ((int'(vx.rot) % 360) + 360) % 360;
      d = m % 90;
      case (quad_type'(m / 90))
         QUAD_0:   begin sn = sine_q14[d];       cs = sine_q14[90 - d];  end
         QUAD_90:  begin sn = sine_q14[90 - d];  cs = -sine_q14[d];      end
         QUAD_180: begin sn = -sine_q14[d];      cs = -sine_q14[90 - d]; end
         default:  begin sn = -sine_q14[90 - d]; cs = sine_q14[d];       end
      endcase
      // s vector is +1 on its axis, t vector is -1 on its axis
      case (ax)
         AXIS_FLOOR, AXIS_CEILING: begin ps = vx.px; pt = vx.py; end
         AXIS_WEST, AXIS_EAST:     begin ps = vx.py; pt = vx.pz; end
         default:                  begin ps = vx.px; pt = vx.pz; end
      endcase
      r.u = project_axis(ps * cs + pt * sn, vx.scl_s, vx.off_s, width_reg);
      r.v = project_axis(ps * sn - pt * cs, vx.scl_t, vx.off_t, height_reg);
      return r;
   endfunction

   task automatic send_vertex(vertex_type vx);
      int gap;
      gap = steady ? 0 : $urandom_range(16);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata = {vx.scl_t, vx.scl_s, vx.off_t, vx.off_s, vx.rot,
                   vx.nz, vx.ny, vx.nx, vx.pz, vx.py, vx.px};
      req_tvalid = 1'b1;
      do @(posedge clock); while (!req_tready);
      coord_q.insert(coord_q.size(), texture_coords(vx));
   endtask

   // drain everything, then let the pipeline settle before a register write
   task automatic write_size(logic [CSR_IDX_W-1:0] idx, logic [SIZE_W-1:0] val);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (coord_q.size() > 0) @(posedge clock);
      repeat (115) @(negedge clock);
      csr_wen = 1'b1;
      csr_addr = idx;
      csr_wdata = val;
      @(negedge clock);
      csr_wen = 1'b0;
      if (idx == CSR_TEX_WIDTH) width_reg = val;
      else height_reg = val;
   endtask

   function automatic vertex_type make_vertex(int x, int y, int z, int nx, int ny, int nz,
                                              int rot, int os, int ot, int ss, int st);
      vertex_type vx;
      vx.px = x; vx.py = y; vx.pz = z;
      vx.nx = 16'(nx); vx.ny = 16'(ny); vx.nz = 16'(nz);
      vx.rot = 16'(rot); vx.off_s = 16'(os); vx.off_t = 16'(ot);
      vx.scl_s = 16'(ss); vx.scl_t = 16'(st);
      return vx;
   endfunction

   function automatic vertex_type random_vertex();
      vertex_type vx;
      int sel;
      sel = $urandom_range(3);
      vx.px = (sel == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
      vx.py = (sel == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
      vx.pz = (sel == 0) ? $urandom : $signed($urandom_range(2000000)) - 1000000;
      if ($urandom_range(3) == 0) begin
         // axis-aligned or tied normals
         vx.nx = 16'(16384 * ($signed($urandom_range(2)) - 1));
         vx.ny = 16'(16384 * ($signed($urandom_range(2)) - 1));
         vx.nz = 16'(16384 * ($signed($urandom_range(2)) - 1));
      end else begin
         vx.nx = 16'($signed($urandom_range(32768)) - 16384);
         vx.ny = 16'($signed($urandom_range(32768)) - 16384);
         vx.nz = 16'($signed($urandom_range(32768)) - 16384);
      end
      vx.rot = 16'(($urandom_range(1) == 0) ? $urandom : 90 * $urandom_range(7));
      vx.off_s = 16'($urandom);
      vx.off_t = 16'($urandom);
      sel = $urandom_range(5);
      vx.scl_s = (sel == 0) ? 16'sd0 : (sel == 1) ? 16'($signed($urandom_range(512)) - 256)
                                                  : 16'($urandom);
      sel = $urandom_range(5);
      vx.scl_t = (sel == 0) ? 16'sd0 : (sel == 1) ? 16'($signed($urandom_range(512)) - 256)
                                                  : 16'($urandom);
      return vx;
   endfunction

   task automatic test_axis_choice();
      send_vertex(make_vertex(65536, 131072, -65536, 0, 0, 16384, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, 0, 0, -16384, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, 16384, 0, 0, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, -16384, 0, 0, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, 0, 16384, 0, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, 0, -16384, 0, 0, 0, 0, 256, 256));
      // zero normal and ties keep the earlier candidate
      send_vertex(make_vertex(65536, 131072, -65536, 0, 0, 0, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, 9000, 9000, 9000, 0, 0, 0, 256, 256));
      send_vertex(make_vertex(65536, 131072, -65536, -9000, 9000, 0, 0, 0, 0, 256, 256));
   endtask

   task automatic test_rotation();
      int angles[10] = '{0, 90, 180, 270, 45, -90, 359, 360, -32768, 32767};
      foreach (angles[i])
         send_vertex(make_vertex(123456, -654321, 98765, 3000, -2000, 12000,
                                 angles[i], 3, -5, 256, 256));
   endtask

   task automatic test_extremes();
      send_vertex(make_vertex(32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0, 16384,
                              45, 32767, -32768, 1, -1));
      send_vertex(make_vertex(32'h80000000, 32'h7fffffff, 32'h80000000, -16384, 0, 0,
                              0, -32768, 32767, -32768, 32767));
      send_vertex(make_vertex(-200000, 300000, 7, 0, -16384, 0, 30, 0, 0, 0, 0));
      send_vertex(make_vertex(-200000, 300000, 7, 0, 16384, 0, 30, 1, -1, -256, -128));
      send_vertex(make_vertex(-1, -1, -1, 16384, 0, 0, 0, -1, -1, 32767, -32768));
   endtask

   task automatic test_random_phase(int count, logic [SIZE_W-1:0] w,
                                    logic [SIZE_W-1:0] h);
      write_size(CSR_TEX_WIDTH, w);
      write_size(CSR_TEX_HEIGHT, h);
      for (int i = 0; i < count; i++) begin
         if (i % 60 == 0) steady = ($urandom_range(3) == 0);
         send_vertex(random_vertex());
      end
      steady = 1'b0;
   endtask

   // result side: random stall before each item
   initial begin
      int n;
      forever begin
         n = steady ? 0 : $urandom_range(16);
         if (n > 0) begin
            rsp_tready = 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      coord_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (coord_q.size() == 0) begin
            $display("%0t: unexpected result u=%h v=%h", $time,
                     rsp_tdata[31:0], rsp_tdata[63:32]);
            errors++;
         end else begin
            want = coord_q.pop_front();
            if (rsp_tdata[31:0] !== want.u) begin
               $display("%0t: coord_u expected %h actual %h", $time, want.u,
                        rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[63:32] !== want.v) begin
               $display("%0t: coord_v expected %h actual %h", $time, want.v,
                        rsp_tdata[63:32]);
               errors++;
            end
         end
      end
   end

   // watchdog: count cycles with no item moving on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("planar_texture_coord_gen_core: mismatch");
         $finish;
      end
   end

   initial begin
      width_reg = TEX_SIZE_RESET;
      height_reg = TEX_SIZE_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_axis_choice();
      test_rotation();
      test_extremes();
      test_random_phase(250, 13'd64, 13'd64);
      test_random_phase(200, 13'd1, 13'd4096);
      test_random_phase(200, 13'd0, 13'd8191);
      test_random_phase(200, 13'd4096, 13'd0);
      test_random_phase(250, SIZE_W'($urandom_range(8191)), SIZE_W'($urandom_range(8191)));
      test_random_phase(226, 13'd8191, 13'd1);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (coord_q.size() > 0) @(posedge clock);
      repeat (120) @(posedge clock);
      if (errors == 0)
         $display("planar_texture_coord_gen_core: match");
      else
         $display("planar_texture_coord_gen_core: mismatch");
      $finish;
   end

endmodule

// File: files.f
rtl/core/ptcg_pkg.sv
rtl/core/ptcg_lane.sv
rtl/core/planar_texture_coord_gen_core.sv
verif/tb_planar_texture_coord_gen_core.sv
